// ===== src/mpfd_pkg.sv =====
// Package for the page framebuffer: command codes, the front-to-back queue entry and the back-end states.
`default_nettype none
package mpfd_pkg;
	localparam logic [2:0] CMD_CLEAR = 3'd0;
	localparam logic [2:0] CMD_PIXEL = 3'd1;
	localparam logic [2:0] CMD_HLINE = 3'd2;
	localparam logic [2:0] CMD_VLINE = 3'd3;
	localparam logic [2:0] CMD_RECT  = 3'd4;
	localparam logic [2:0] CMD_FILL  = 3'd5;
	localparam logic [2:0] CMD_READ  = 3'd6;

	// One drawing job: a span of pixels on column range [xa,xb] and row range [ya,yb].
	typedef struct packed {
		logic               is_clear;
		logic               is_read;
		logic               is_draw;
		logic               last;
		logic               status;
		logic               color;
		logic [9:0]         addr;
		logic signed [17:0] xa;
		logic signed [17:0] xb;
		logic signed [17:0] ya;
		logic signed [17:0] yb;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_CLEAR, ST_RD, ST_RMW_R, ST_RMW_W, ST_OUT
	} back_state_t;
endpackage
`default_nettype wire

// ===== src/mono_page_framebuffer_drawing.sv =====
// Top level of the page-organized monochrome framebuffer with drawing commands.
// Usage:
//  s_axis carries one command request per transfer; tdata packs, from bit 0 up:
//  command[2:0], x_pos, y_pos, x_second, y_second, color, byte_address (78 of the 80 bits).
//  m_axis returns exactly one result per command; tdata packs status, read_data.
//  The front decodes a command into span jobs (four for a rectangle outline)
//  and queues them; the back walks each span byte by byte over the store with
//  a read-modify-write, a read state then a write state per touched byte, as
//  the store is a single-port memory. A clear command rewrites every byte.
//  After reset the back runs a clearing pass over every store byte before the
//  first command executes.
//  If m_axis_tready is low the result is held and the back stalls; the front
//  may still decode the next request into the queue.
`default_nettype none
module mono_page_framebuffer_drawing import mpfd_pkg::*; #(
	parameter int DISPLAY_WIDTH  = 128,
	parameter int DISPLAY_HEIGHT = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// command, x_pos, y_pos, x_second, y_second, color, byte_address
	input  wire  [79:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// status, read_data
	output logic [15:0] m_axis_tdata
);
	localparam int BYTES = DISPLAY_WIDTH * ((DISPLAY_HEIGHT + 7) / 8);

	logic push, full, pop, empty, status;
	job_t qin, qout;
	logic [7:0] rd;

	mpfd_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.command(s_axis_tdata[2:0]), .x_pos(s_axis_tdata[18:3]),
		.y_pos(s_axis_tdata[34:19]), .x_second(s_axis_tdata[50:35]),
		.y_second(s_axis_tdata[66:51]), .color(s_axis_tdata[67]),
		.byte_address(s_axis_tdata[77:68]),
		.store_bytes(13'(BYTES)), .width(9'(DISPLAY_WIDTH)), .height(8'(DISPLAY_HEIGHT)),
		.push(push), .job(qin), .full(full));

	mpfd_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .din(qin), .full(full),
		.pop(pop), .dout(qout), .empty(empty));

	mpfd_back #(.DISPLAY_WIDTH(DISPLAY_WIDTH), .DISPLAY_HEIGHT(DISPLAY_HEIGHT)) u_back (
		.clk(clk), .arst_n(arst_n), .empty(empty), .job(qout), .pop(pop),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.status(status), .read_data(rd));

	assign m_axis_tdata = {7'd0, rd, status};
endmodule
`default_nettype wire

// ===== src/mpfd_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module mpfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] addr,
	input  wire [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// ===== src/mpfd_front.sv =====
// Front end: decodes a command into up to four span jobs and pushes them to the queue.
`default_nettype none
module mpfd_front import mpfd_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [2:0]  command,
	input  wire  [15:0] x_pos,
	input  wire  [15:0] y_pos,
	input  wire  [15:0] x_second,
	input  wire  [15:0] y_second,
	input  wire         color,
	input  wire  [9:0]  byte_address,
	input  wire  [12:0] store_bytes,
	input  wire  [8:0]  width,
	input  wire  [7:0]  height,
	output logic        push,
	output job_t        job,
	input  wire         full
);
	job_t        jobs_q [4];
	logic [2:0]  cnt_q;
	logic [1:0]  idx_q;
	logic signed [17:0] x, y, xs, ys, xe, ye, yf;
	job_t base;
	job_t j [4];
	logic [2:0] n;

	assign x  = 18'(signed'(x_pos));
	assign y  = 18'(signed'(y_pos));
	assign xs = 18'(signed'(x_second));
	assign ys = 18'(signed'(y_second));
	assign xe = 18'(signed'(16'(x_pos + x_second - 16'd1)));
	assign ye = 18'(signed'(16'(y_pos + y_second - 16'd1)));
	assign yf = y + ys - 18'sd1;

	function automatic job_t span(job_t b, logic signed [17:0] a0, logic signed [17:0] a1,
		logic signed [17:0] b0, logic signed [17:0] b1);
		job_t r;
		r = b;
		r.is_draw = 1'b1;
		r.xa = (a0 > a1) ? a1 : a0;
		r.xb = (a0 > a1) ? a0 : a1;
		r.ya = (b0 > b1) ? b1 : b0;
		r.yb = (b0 > b1) ? b0 : b1;
		return r;
	endfunction

	always_comb begin
		base = '0;
		base.color = color;
		base.addr = byte_address;
		for (int i = 0; i < 4; i++) j[i] = base;
		n = 3'd1;
		unique case (command)
			CMD_CLEAR: j[0].is_clear = 1'b1;
			CMD_PIXEL: begin
				if (x >= 0 && x < 18'(width) && y >= 0 && y < 18'(height))
					j[0] = span(base, x, x, y, y);
				else
					j[0].status = 1'b1;
			end
			CMD_HLINE: j[0] = span(base, x, xs, y, y);
			CMD_VLINE: j[0] = span(base, x, x, y, ys);
			CMD_RECT: begin
				j[0] = span(base, x, xe, y, y);
				j[1] = span(base, x, xe, ye, ye);
				j[2] = span(base, x, x, y, ye);
				j[3] = span(base, xe, xe, y, ye);
				n = 3'd4;
			end
			CMD_FILL: begin
				if (ys > 0) begin
					j[0] = span(base, x, xe, y, yf);
				end
			end
			CMD_READ: j[0].is_read = (13'(byte_address) < store_bytes);
			default: ;
		endcase
		for (int i = 0; i < 4; i++) j[i].last = (3'(i) == n - 3'd1);
	end

	assign in_ready = (cnt_q == 3'd0);
	assign push = (cnt_q != 3'd0) && !full;
	assign job = jobs_q[idx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (in_valid && in_ready) begin
			cnt_q <= n;
			idx_q <= '0;
		end else if (push) begin
			cnt_q <= cnt_q - 3'd1;
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			for (int i = 0; i < 4; i++) jobs_q[i] <= j[i];
	end
endmodule
`default_nettype wire

// ===== src/mpfd_queue.sv =====
// Short job queue between front and back.
`default_nettype none
module mpfd_queue import mpfd_pkg::*; (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   push,
	input  job_t  din,
	output logic  full,
	input  wire   pop,
	output job_t  dout,
	output logic  empty
);
	job_t       mem_q [4];
	logic [2:0] wp_q, rp_q;
	assign full  = (wp_q[1:0] == rp_q[1:0]) && (wp_q[2] != rp_q[2]);
	assign empty = (wp_q == rp_q);
	assign dout  = mem_q[rp_q[1:0]];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (push && !full) wp_q <= wp_q + 3'd1;
			if (pop && !empty) rp_q <= rp_q + 3'd1;
		end
	end
	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q[1:0]] <= din;
	end
endmodule
`default_nettype wire

// ===== src/mpfd_back.sv =====
// Back end: walks the bytes of each span with read-modify-write, clears and reads the store.
`default_nettype none
module mpfd_back import mpfd_pkg::*; #(
	parameter int DISPLAY_WIDTH  = 128,
	parameter int DISPLAY_HEIGHT = 64
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        empty,
	input  job_t       job,
	output logic       pop,
	output logic       out_valid,
	input  wire        out_ready,
	output logic       status,
	output logic [7:0] read_data
);
	localparam int PAGES = (DISPLAY_HEIGHT + 7) / 8;
	localparam int BYTES = DISPLAY_WIDTH * PAGES;
	localparam int AW = $clog2(BYTES);
	localparam int XW = $clog2(DISPLAY_WIDTH);
	localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1;

	back_state_t st_q, st_d;
	// clearing pass address, used after reset and for the clear command
	logic [AW-1:0] clr_q;
	logic          init_q;
	logic [XW-1:0] cx_q, x0_q, x1_q;
	logic [PW-1:0] cp_q, p1_q;
	logic [6:0]    y0_q, y1_q;
	logic          color_q, status_q, last_q;
	logic [7:0]    data_q;
	logic [7:0]    rdata, mask;
	logic          we;
	logic [AW-1:0] addr;
	logic [7:0]    wdata;
	logic          empty_span;
	logic signed [17:0] ca, cb, ra, rb;

	mpfd_ram #(.WIDTH(8), .DEPTH(BYTES)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

	// clip span to the screen
	always_comb begin
		ca = (job.xa < 0) ? 18'sd0 : job.xa;
		cb = (job.xb > DISPLAY_WIDTH - 1) ? 18'(DISPLAY_WIDTH - 1) : job.xb;
		ra = (job.ya < 0) ? 18'sd0 : job.ya;
		rb = (job.yb > DISPLAY_HEIGHT - 1) ? 18'(DISPLAY_HEIGHT - 1) : job.yb;
		empty_span = (ca > cb) || (ra > rb);
	end

	// bits of the current page inside rows y0..y1
	always_comb begin
		for (int b = 0; b < 8; b++) begin
			mask[b] = (10'({cp_q, 3'(b)}) >= 10'(y0_q)) && (10'({cp_q, 3'(b)}) <= 10'(y1_q));
		end
	end

	always_comb begin
		we = 1'b0;
		wdata = '0;
		pop = 1'b0;
		addr = AW'(cp_q) * AW'(DISPLAY_WIDTH) + AW'(cx_q);
		unique case (st_q)
			ST_CLEAR: begin
				we = 1'b1;
				addr = clr_q;
			end
			ST_RMW_W: begin
				we = 1'b1;
				wdata = color_q ? (rdata | mask) : (rdata & ~mask);
			end
			ST_IDLE: begin
				addr = AW'(job.addr);
				pop = !init_q && !empty;
			end
			default: ;
		endcase
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (!init_q && !empty) begin
				if (job.is_clear) st_d = ST_CLEAR;
				else if (job.is_read) st_d = ST_RD;
				else if (job.is_draw && !empty_span) st_d = ST_RMW_R;
				else if (job.last) st_d = ST_OUT;
			end else if (init_q) st_d = ST_CLEAR;
			ST_CLEAR: if (clr_q == AW'(BYTES - 1))
				st_d = init_q ? ST_IDLE : ST_OUT;
			ST_RD: st_d = ST_OUT;
			ST_RMW_R: st_d = ST_RMW_W;
			ST_RMW_W: begin
				if (cx_q != x1_q) st_d = ST_RMW_R;
				else if (cp_q != p1_q) st_d = ST_RMW_R;
				else st_d = last_q ? ST_OUT : ST_IDLE;
			end
			ST_OUT: if (out_ready) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_CLEAR;
			init_q <= 1'b1;
			clr_q  <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_CLEAR) begin
				clr_q <= (clr_q == AW'(BYTES - 1)) ? '0 : clr_q + 1'b1;
				if (clr_q == AW'(BYTES - 1)) init_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && pop) begin
			color_q  <= job.color;
			status_q <= job.status;
			last_q   <= job.last;
			data_q   <= '0;
			x0_q <= XW'(ca);
			x1_q <= XW'(cb);
			cx_q <= XW'(ca);
			y0_q <= 7'(ra);
			y1_q <= 7'(rb);
			cp_q <= PW'(ra >>> 3);
			p1_q <= PW'(rb >>> 3);
		end
		if (st_q == ST_RD) data_q <= rdata;
		if (st_q == ST_RMW_W) begin
			if (cx_q != x1_q) cx_q <= cx_q + 1'b1;
			else begin
				cx_q <= x0_q;
				cp_q <= cp_q + 1'b1;
			end
		end
	end

	assign out_valid = (st_q == ST_OUT);
	assign status    = status_q;
	assign read_data = data_q;

	a_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data)) else $error("result lost");
	a_clear_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> !out_valid) else $error("result during reset clear");
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (st_q == ST_CLEAR || st_q == ST_RMW_W)) else $error("stray write");
endmodule
`default_nettype wire

// ===== test/mono_page_framebuffer_drawing_test.sv =====
// Self-checking testbench for the page framebuffer: random drawing requests against a pixel model.
`timescale 1ns / 1ps
`default_nettype none
module mono_page_framebuffer_drawing_test import mpfd_pkg::*;;

	localparam int WIDTH = 128;
	localparam int HEIGHT = 64;
	localparam int STORE_BYTES = WIDTH * ((HEIGHT + 7) / 8);
	localparam int WATCHDOG_LIMIT = 40000;
	localparam int DRAIN_CYCLES = 2500;
	localparam logic [2:0] CMD_SPARE = 3'd7;

	typedef struct packed {
		logic [9:0]  byte_address;
		logic        color;
		logic [15:0] y_second;
		logic [15:0] x_second;
		logic [15:0] y_pos;
		logic [15:0] x_pos;
		logic [2:0]  command;
	} draw_req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       status;
	} draw_resp_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;

	mono_page_framebuffer_drawing u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		// command, x_pos, y_pos, x_second, y_second, color, byte_address
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		// status, read_data
		.m_axis_tdata  (m_axis_tdata)
	);

	// Shadow copy of the framebuffer, updated as each request is accepted.
	logic [7:0] shadow_fb [STORE_BYTES];
	draw_req_t  pending_reqs[$];
	draw_resp_t expected_resps[$];
	int         send_idle_pct;
	int         recv_stall_pct;
	int         error_count;
	int         idle_cycles;
	int         req_count;
	int         resp_count;
	bit         stim_done;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// --- pixel model ---
	function automatic bit on_screen(int x, int y);
		return x >= 0 && x < WIDTH && y >= 0 && y < HEIGHT;
	endfunction

	function automatic void plot(int x, int y, bit c);
		int idx;
		if (on_screen(x, y)) begin
			idx = x + (y / 8) * WIDTH;
			shadow_fb[idx][y % 8] = c;
		end
	endfunction

	function automatic void draw_hspan(int a, int y, int b, bit c);
		int t;
		if (a > b) begin
			t = a; a = b; b = t;
		end
		if (y < 0 || y >= HEIGHT)
			return;
		if (a < 0) a = 0;
		if (b > WIDTH - 1) b = WIDTH - 1;
		for (int x = a; x <= b; x++)
			plot(x, y, c);
	endfunction

	function automatic void draw_vspan(int x, int a, int b, bit c);
		int t;
		if (a > b) begin
			t = a; a = b; b = t;
		end
		if (x < 0 || x >= WIDTH)
			return;
		if (a < 0) a = 0;
		if (b > HEIGHT - 1) b = HEIGHT - 1;
		for (int y = a; y <= b; y++)
			plot(x, y, c);
	endfunction

	// Apply one request to the shadow framebuffer and return its response.
	function automatic draw_resp_t apply_draw(draw_req_t r);
		draw_resp_t   rsp;
		int           x, y, xs, ys, lo, hi;
		logic [15:0]  xe16, ye16;
		int           xe, ye;
		x = $signed(r.x_pos);
		y = $signed(r.y_pos);
		xs = $signed(r.x_second);
		ys = $signed(r.y_second);
		// far rectangle edges wrap to 16 bits
		xe16 = 16'(x + xs - 1);
		ye16 = 16'(y + ys - 1);
		xe = $signed(xe16);
		ye = $signed(ye16);
		rsp = '0;
		case (r.command)
			CMD_CLEAR: begin
				for (int i = 0; i < STORE_BYTES; i++)
					shadow_fb[i] = 8'h00;
			end
			CMD_PIXEL: begin
				if (on_screen(x, y))
					plot(x, y, r.color);
				else
					rsp.status = 1'b1;
			end
			CMD_HLINE: draw_hspan(x, y, xs, r.color);
			CMD_VLINE: draw_vspan(x, y, ys, r.color);
			CMD_RECT: begin
				draw_hspan(x, y, xe, r.color);
				draw_hspan(x, ye, xe, r.color);
				draw_vspan(x, y, ye, r.color);
				draw_vspan(xe, y, ye, r.color);
			end
			CMD_FILL: begin
				// fill rows do not wrap; non-positive height draws nothing
				if (ys > 0) begin
					lo = y < 0 ? 0 : y;
					hi = y + ys - 1;
					if (hi > HEIGHT - 1) hi = HEIGHT - 1;
					for (int j = lo; j <= hi; j++)
						draw_hspan(x, j, xe, r.color);
				end
			end
			CMD_READ: begin
				if (r.byte_address < STORE_BYTES)
					rsp.read_data = shadow_fb[r.byte_address];
			end
			default: ;
		endcase
		return rsp;
	endfunction

	// --- stimulus builders ---
	function automatic draw_req_t make_req(logic [2:0] cmd, int x, int y, int xs, int ys,
			bit c, int addr);
		draw_req_t r;
		r.command = cmd;
		r.x_pos = 16'(x);
		r.y_pos = 16'(y);
		r.x_second = 16'(xs);
		r.y_second = 16'(ys);
		r.color = c;
		r.byte_address = 10'(addr);
		return r;
	endfunction

	// Coordinate mostly near the screen, sometimes anywhere in 16 bits.
	function automatic int rand_coord(int span);
		case ($urandom_range(0, 9))
			0: return $signed(16'($urandom));
			1: return -int'($urandom_range(1, 20));
			default: return int'($urandom_range(0, span + 8));
		endcase
	endfunction

	function automatic draw_req_t rand_req();
		draw_req_t r;
		int        pick;
		r = draw_req_t'(78'({$urandom, $urandom, $urandom}));
		pick = $urandom_range(0, 99);
		if (pick < 1)
			r.command = CMD_CLEAR;
		else if (pick < 22)
			r.command = CMD_PIXEL;
		else if (pick < 34)
			r.command = CMD_HLINE;
		else if (pick < 46)
			r.command = CMD_VLINE;
		else if (pick < 54)
			r.command = CMD_RECT;
		else if (pick < 60)
			r.command = CMD_FILL;
		else if (pick < 98)
			r.command = CMD_READ;
		else
			r.command = CMD_SPARE;
		// well-formed geometry most of the time, raw bits otherwise
		if ($urandom_range(0, 9) != 0) begin
			r.x_pos = 16'(rand_coord(WIDTH));
			r.y_pos = 16'(rand_coord(HEIGHT));
			if (r.command == CMD_HLINE)
				r.x_second = 16'(rand_coord(WIDTH));
			else if (r.command == CMD_RECT || r.command == CMD_FILL)
				r.x_second = 16'(int'($urandom_range(0, 40)) - 4);
			if (r.command == CMD_VLINE)
				r.y_second = 16'(rand_coord(HEIGHT));
			else if (r.command == CMD_RECT || r.command == CMD_FILL)
				r.y_second = 16'(int'($urandom_range(0, 24)) - 4);
			if (r.command == CMD_READ && $urandom_range(0, 19) != 0)
				r.byte_address = 10'($urandom_range(0, STORE_BYTES - 1));
		end
		return r;
	endfunction

	task automatic push_directed();
		pending_reqs.push_back(make_req(CMD_PIXEL, 0, 0, 0, 0, 1, 0));
		pending_reqs.push_back(make_req(CMD_PIXEL, WIDTH - 1, HEIGHT - 1, 0, 0, 1, 0));
		pending_reqs.push_back(make_req(CMD_PIXEL, -1, 5, 0, 0, 1, 0));
		pending_reqs.push_back(make_req(CMD_PIXEL, 5, HEIGHT, 0, 0, 1, 0));
		pending_reqs.push_back(make_req(CMD_PIXEL, 32767, -32768, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(CMD_READ, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(CMD_READ, 0, 0, 0, 0, 0, STORE_BYTES - 1));
		// reversed endpoints, clipped ends
		pending_reqs.push_back(make_req(CMD_HLINE, 200, 9, -50, 0, 1, 0));
		pending_reqs.push_back(make_req(CMD_VLINE, 64, 100, -3, 0, 1, 0));
		pending_reqs.push_back(make_req(CMD_HLINE, -32768, 17, 32767, 0, 0, 0));
		pending_reqs.push_back(make_req(CMD_RECT, 10, 10, 20, 12, 1, 0));
		// non-positive width still draws a swapped span; wrapping far edge
		pending_reqs.push_back(make_req(CMD_RECT, 60, 30, -5, 0, 1, 0));
		pending_reqs.push_back(make_req(CMD_RECT, 32767, 20, 2, 5, 1, 0));
		pending_reqs.push_back(make_req(CMD_FILL, 40, 40, 10, 6, 1, 0));
		pending_reqs.push_back(make_req(CMD_FILL, 40, 40, 10, 0, 1, 0));
		pending_reqs.push_back(make_req(CMD_FILL, 5, 60, 8, -3, 1, 0));
		pending_reqs.push_back(make_req(CMD_FILL, 44, 42, 3, 2, 0, 0));
		pending_reqs.push_back(make_req(CMD_READ, 0, 0, 0, 0, 0, 5 * WIDTH + 44));
		pending_reqs.push_back(make_req(CMD_READ, 0, 0, 0, 0, 0, STORE_BYTES));
		pending_reqs.push_back(make_req(CMD_READ, 0, 0, 0, 0, 0, 1023));
		pending_reqs.push_back(make_req(CMD_SPARE, 1, 1, 1, 1, 1, 1));
		pending_reqs.push_back(make_req(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(CMD_READ, 0, 0, 0, 0, 0, 1 * WIDTH + 10));
	endtask

	// --- driver: one request per handshake, random idle gaps ---
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_resps.push_back(apply_draw(draw_req_t'(s_axis_tdata)));
				req_count <= req_count + 1;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= pending_reqs.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// --- monitor: check responses and pace tready ---
	always @(posedge clk or negedge arst_n) begin
		draw_resp_t got, want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= $urandom_range(0, 99) >= recv_stall_pct;
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[8:0];
				resp_count <= resp_count + 1;
				if (expected_resps.size() == 0) begin
					$error("response with no request pending: status %0d read_data %02h",
						got.status, got.read_data);
					error_count <= error_count + 1;
				end else begin
					want = expected_resps.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						error_count <= error_count + 1;
					end
					if (got.read_data !== want.read_data) begin
						$error("read_data: expected %02h, got %02h", want.read_data,
							got.read_data);
						error_count <= error_count + 1;
					end
				end
			end
		end
	end

	// --- watchdog: cycles with no handshake on either side ---
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else if (!stim_done || expected_resps.size() > 0)
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no traffic for %0d cycles", idle_cycles);
				$display("** mono_page_framebuffer_drawing: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		error_count = 0;
		idle_cycles = 0;
		req_count = 0;
		resp_count = 0;
		stim_done = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < STORE_BYTES; i++)
			shadow_fb[i] = 8'h00;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		push_directed();
		// four pacing phases: free-running, sender gaps, receiver stalls, both
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1) ? 48 : (phase == 3) ? 29 : 0;
			recv_stall_pct = (phase == 2) ? 48 : (phase == 3) ? 29 : 0;
			for (int i = 0; i < 320; i++)
				pending_reqs.push_back(rand_req());
			while (pending_reqs.size() > 0)
				@(posedge clk);
		end
		stim_done = 1;
		while (expected_resps.size() > 0 || s_axis_tvalid)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d drawing and read requests, %0d responses checked,", req_count,
			resp_count);
		$display("over four pacing phases with clipping, reversal and wrap cases");
		if (error_count == 0 && expected_resps.size() == 0)
			$display("** mono_page_framebuffer_drawing: PASSED **");
		else
			$display("** mono_page_framebuffer_drawing: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire
